// ===== rtl/f32rs_pkg.sv =====
// ============================================================================
// f32rs_pkg
// Shared types and constants for the single-precision rsqrt estimate.
// ============================================================================
`default_nettype none

package f32rs_pkg;

    typedef logic [31:0] word_t;

    localparam word_t NEG_INF_BITS = 32'hFF80_0000;
    localparam word_t POS_INF_BITS = 32'h7F80_0000;
    localparam word_t DEFAULT_NAN  = 32'h7FC0_0000;
    localparam word_t QUIET_BIT    = 32'h0040_0000;
    localparam word_t ZERO_BITS    = 32'h0000_0000;

    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
    localparam logic [9:0] EXP_BIAS_HALF = 10'd63;

    // slope in [31:16], base in [15:0]; index is {exponent lsb, mantissa[22:19]}
    localparam word_t RSQ_TABLE [32] = '{
        32'h0568B4FD, 32'h04F3AF97, 32'h048DAAA5, 32'h0435A618,
        32'h03E7A1E4, 32'h03A29DFE, 32'h03659A5C, 32'h032E96F8,
        32'h02FC93CA, 32'h02D090CE, 32'h02A88DFE, 32'h02838B57,
        32'h026188D4, 32'h02438673, 32'h02268431, 32'h020B820B,
        32'h03D27FFA, 32'h03807C29, 32'h033878AA, 32'h02F97572,
        32'h02C27279, 32'h02926FB7, 32'h02666D26, 32'h023F6AC0,
        32'h021D6881, 32'h01FD6665, 32'h01E16468, 32'h01C76287,
        32'h01AF60C1, 32'h01995F12, 32'h01855D79, 32'h01735BF4
    };

endpackage

`default_nettype wire

// ===== rtl/f32rs_core.sv =====
// ============================================================================
// f32rs_core
// Table lookup, linear interpolation, normalize, round, assemble, specials.
// ============================================================================
`default_nettype none

module f32rs_core
(
    input  wire f32rs_pkg::word_t operand,
    output f32rs_pkg::word_t      estimate
);

    logic        sign;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [4:0]  idx;
    logic [9:0]  interp;
    logic [15:0] slope;
    logic [15:0] base16;
    logic [25:0] base;
    logic [25:0] prod;
    logic [25:0] raw;
    logic [24:0] val;
    logic [4:0]  lz25;
    logic [4:0]  sh;
    logic [24:0] norm;
    logic [24:0] rounded;
    logic [6:0]  half_exp;
    logic [9:0]  res_exp;
    logic [8:0]  exp_field;
    logic [22:0] res_mant;
    f32rs_pkg::word_t assembled;

    assign sign   = operand[31];
    assign bexp   = operand[30:23];
    assign mant   = operand[22:0];
    assign idx    = {bexp[0], mant[22:19]};
    assign interp = mant[18:9];
    assign slope  = f32rs_pkg::RSQ_TABLE[idx][31:16];
    assign base16 = f32rs_pkg::RSQ_TABLE[idx][15:0];
    assign base   = {base16, 10'd0};
    assign prod   = 26'(interp) * 26'(slope);
    assign raw    = base - prod;
    assign val    = raw[24:0];

    always_comb
    begin
        lz25 = 5'd25;
        for (int i = 0; i < 25; i++)
        begin
            if (val[i])
            begin
                lz25 = 5'(24 - i);
            end
        end
    end

    assign sh       = raw[25] ? 5'd0 : 5'(lz25 + 5'd1);
    assign norm     = val << sh;
    assign rounded  = (norm[1] && (norm[0] || norm[2])) ? 25'(norm + 25'd4) : norm;
    assign half_exp = 7'((8'hFF - bexp) >> 1);
    assign res_exp  = {3'd0, half_exp} + f32rs_pkg::EXP_BIAS_HALF - {5'd0, sh};
    assign exp_field = res_exp[8:0];
    assign res_mant  = rounded[24:2];
    assign assembled = {exp_field, res_mant};

    always_comb
    begin
        if (operand == f32rs_pkg::NEG_INF_BITS)
        begin
            estimate = f32rs_pkg::DEFAULT_NAN;
        end
        else if (bexp == 8'd0)
        begin
            estimate = sign ? f32rs_pkg::NEG_INF_BITS : f32rs_pkg::POS_INF_BITS;
        end
        else if (bexp == f32rs_pkg::EXP_ALL_ONES)
        begin
            estimate = (mant == 23'd0) ? f32rs_pkg::ZERO_BITS
                                       : (operand | f32rs_pkg::QUIET_BIT);
        end
        else if (sign)
        begin
            estimate = f32rs_pkg::DEFAULT_NAN;
        end
        else if (assembled[30:23] == 8'd0 && res_mant != 23'd0)
        begin
            estimate = f32rs_pkg::ZERO_BITS;
        end
        else
        begin
            estimate = assembled;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fp32_rsqrt_estimate.sv =====
// ============================================================================
// fp32_rsqrt_estimate
// Single-precision reciprocal square root estimate on raw bits, streaming.
// ============================================================================
// Accepts one operand per cycle while the input is not stalled and returns
// one estimate per operand, in order, from the output register. The
// operand is captured in an input register; the table lookup, 10x16-bit
// interpolation multiply, normalize and round sit between it and the output
// register. Back-pressure on the output holds both registers and stalls the
// input only when both are full. Special operands (zero, denormal, infinity,
// NaN, negative) are resolved in the same pass.
`default_nettype none

module fp32_rsqrt_estimate
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] operand_bits
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] estimate_bits
);

    logic             in_valid_reg;
    f32rs_pkg::word_t in_data_reg;
    logic             out_valid_reg;
    f32rs_pkg::word_t out_data_reg;
    f32rs_pkg::word_t estimate;
    logic             out_load;
    logic             in_valid_next;
    logic             out_valid_next;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    f32rs_core u_core
    (
        .operand  (in_data_reg),
        .estimate (estimate)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= estimate;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_input_held : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a pending transaction");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted transaction not captured");

    a_output_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("output valid without a pending operand");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled while pipeline has room");
`endif

endmodule

`default_nettype wire
